FILE: rtl/pfa_pkg.sv
package pfa_pkg;

   // default sizing
   localparam int DEF_ENTRIES   = 16;
   localparam int DEF_ADDR_BITS = 20;

   // fixed field widths
   localparam int BASE_W   = 20;
   localparam int LEN_W    = 21;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;

   // command codes (req_tuser)
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   // fit policy codes; the unused code falls back to first fit
   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   // register indexes
   localparam logic CSR_FIT_POLICY   = 1'b0;
   localparam logic CSR_SPLIT_ENABLE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_FULL    = 2'd2,
      ST_LOADED  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DECIDE,
      FSM_GRANT,
      FSM_DONE
   } fsm_state_type;

endpackage

FILE: rtl/partition_fit_allocator.sv
// Channel | Dir | Handshake             | Payload
// req     | in  | req_tvalid/req_tready | tuser: cmd; tdata: load_base, load_length,
//         |     |                       |   request_size
// rsp     | out | rsp_tvalid/rsp_tready | tuser: status; tdata: grant_base, grant_index
// csr     | in  | csr_valid/csr_ready   | csr_index, csr_data (always ready)
//
// A load's result is registered in the cycle that accepts it. An allocate reads
// the table RAM one entry per cycle over the count entries loaded so far (one read
// port, registered read), drains the compare stage, then decides and appends a split
// remainder, then marks the entry busy (skipped without a grant). The next item is
// accepted once the result has moved into the output register.
// Reset is synchronous; it empties the table (count and busy bits), no clearing
// pass is needed. A result that is not taken holds in the output register; the
// next item is accepted meanwhile, and its result waits until the register frees.
module partition_fit_allocator
   import pfa_pkg::*;
#(
   parameter int ENTRIES   = DEF_ENTRIES,
   parameter int ADDR_BITS = DEF_ADDR_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,   // [0] cmd
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [19:0] load_base, [40:20] load_length,
                                              // [61:41] request_size, [63:62] zero
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [STATUS_W-1:0]   rsp_tuser,   // [1:0] status
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [19:0] grant_base, [23:20] grant_index
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [1:0]            csr_data
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int WORD_W = LEN_W + ADDR_BITS;

   // request fields
   logic [BASE_W-1:0] in_base;
   logic [LEN_W-1:0]  in_len;
   logic [LEN_W-1:0]  in_req;
   logic              req_acc;

   assign in_base = req_tdata[BASE_W-1:0];
   assign in_len  = req_tdata[BASE_W +: LEN_W];
   assign in_req  = req_tdata[BASE_W+LEN_W +: LEN_W];
   assign req_acc = req_tvalid && req_tready;

   // control state
   fsm_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ENTRIES-1:0] busy_ff, busy_in;
   logic [1:0]        fit_policy_ff;
   logic              split_enable_ff;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic              pick_vld_ff, pick_vld_in;

   // working payload
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [LEN_W-1:0]     req_ff, req_in;
   logic [IDX_W-1:0]     pick_idx_ff, pick_idx_in;
   logic [LEN_W-1:0]     pick_left_ff, pick_left_in;
   logic [LEN_W-1:0]     pick_len_ff, pick_len_in;
   logic [ADDR_BITS-1:0] pick_base_ff, pick_base_in;
   logic                 split_go_ff, split_go_in;
   status_type           res_status_ff, res_status_in;
   logic [BASE_W-1:0]    res_base_ff, res_base_in;
   logic [INDEX_W-1:0]   res_index_ff, res_index_in;
   status_type           rsp_tuser_ff, rsp_tuser_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // table RAM: {length, base}
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [IDX_W-1:0]  mem_raddr;
   logic [WORD_W-1:0] mem_rdata;

   pfa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // compare stage on the entry read last cycle
   logic [LEN_W-1:0]     rd_len;
   logic [ADDR_BITS-1:0] rd_base;
   logic [LEN_W-1:0]     rd_left;
   logic                 rd_fits;
   logic                 take;

   assign rd_len  = mem_rdata[ADDR_BITS +: LEN_W];
   assign rd_base = mem_rdata[ADDR_BITS-1:0];
   assign rd_left = rd_len - req_ff;
   assign rd_fits = cmp_vld_ff && !busy_ff[cmp_idx_ff] && (rd_len >= req_ff);

   always_comb begin
      case (fit_policy_ff)
         POL_BEST:  take = rd_fits && (!pick_vld_ff || rd_left < pick_left_ff);
         POL_WORST: take = rd_fits && (!pick_vld_ff || rd_left > pick_left_ff);
         default:   take = rd_fits && !pick_vld_ff;
      endcase
   end

   assign req_tready = (state_ff == FSM_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // next state, table updates and result
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      busy_in       = busy_ff;
      scan_in       = scan_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      req_in        = req_ff;
      pick_vld_in   = pick_vld_ff;
      pick_idx_in   = pick_idx_ff;
      pick_left_in  = pick_left_ff;
      pick_len_in   = pick_len_ff;
      pick_base_in  = pick_base_ff;
      split_go_in   = split_go_ff;
      res_status_in = res_status_ff;
      res_base_in   = res_base_ff;
      res_index_in  = res_index_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      mem_we        = 1'b0;
      mem_waddr     = count_ff[IDX_W-1:0];
      mem_wdata     = '0;
      mem_raddr     = scan_ff[IDX_W-1:0];

      // keep the best candidate so far
      if (take) begin
         pick_vld_in  = 1'b1;
         pick_idx_in  = cmp_idx_ff;
         pick_left_in = rd_left;
         pick_len_in  = rd_len;
         pick_base_in = rd_base;
      end

      case (state_ff)
         FSM_IDLE: begin
            if (req_acc) begin
               res_base_in  = '0;
               res_index_in = '0;
               if (req_tuser == CMD_LOAD) begin
                  if (count_ff == CNT_W'(ENTRIES)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     mem_we        = 1'b1;
                     mem_wdata     = {in_len, ADDR_BITS'(in_base)};
                     busy_in[count_ff[IDX_W-1:0]] = 1'b0;
                     count_in      = count_ff + CNT_W'(1);
                     res_status_in = ST_LOADED;
                     res_index_in  = INDEX_W'(count_ff);
                  end
                  state_in = FSM_DONE;
               end else begin
                  req_in      = in_req;
                  scan_in     = '0;
                  pick_vld_in = 1'b0;
                  if (in_req == '0) begin
                     res_status_in = ST_NOFIT;
                     state_in      = FSM_DONE;
                  end else begin
                     state_in = FSM_SCAN;
                  end
               end
            end
         end
         FSM_SCAN: begin
            // issue one read per cycle, drain the compare stage before deciding
            if (scan_ff < count_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + CNT_W'(1);
            end else if (!cmp_vld_ff) begin
               state_in = FSM_DECIDE;
            end
         end
         FSM_DECIDE: begin
            split_go_in = 1'b0;
            if (!pick_vld_ff) begin
               res_status_in = ST_NOFIT;
               state_in      = FSM_DONE;
            end else if (split_enable_ff && pick_len_ff > req_ff) begin
               if (count_ff == CNT_W'(ENTRIES)) begin
                  res_status_in = ST_FULL;
                  state_in      = FSM_DONE;
               end else begin
                  // append the remainder as a free entry
                  mem_we      = 1'b1;
                  mem_wdata   = {pick_len_ff - req_ff,
                                 pick_base_ff + ADDR_BITS'(req_ff)};
                  busy_in[count_ff[IDX_W-1:0]] = 1'b0;
                  count_in    = count_ff + CNT_W'(1);
                  split_go_in = 1'b1;
                  state_in    = FSM_GRANT;
               end
            end else begin
               state_in = FSM_GRANT;
            end
         end
         FSM_GRANT: begin
            busy_in[pick_idx_ff] = 1'b1;
            if (split_go_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pick_idx_ff;
               mem_wdata = {req_ff, pick_base_ff};
            end
            res_status_in = ST_GRANTED;
            res_base_in   = BASE_W'(pick_base_ff);
            res_index_in  = INDEX_W'(pick_idx_ff);
            state_in      = FSM_DONE;
         end
         FSM_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = res_status_ff;
               rsp_tdata_in  = {res_index_ff, res_base_ff};
               state_in      = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= FSM_IDLE;
         count_ff        <= '0;
         busy_ff         <= '0;
         fit_policy_ff   <= POL_FIRST;
         split_enable_ff <= 1'b0;
         rsp_tvalid_ff   <= 1'b0;
         cmp_vld_ff      <= 1'b0;
         pick_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         busy_ff       <= busy_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         cmp_vld_ff    <= cmp_vld_in;
         pick_vld_ff   <= pick_vld_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FIT_POLICY:   fit_policy_ff   <= csr_data;
               CSR_SPLIT_ENABLE: split_enable_ff <= csr_data[0];
               default:          fit_policy_ff   <= fit_policy_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      req_ff        <= req_in;
      pick_idx_ff   <= pick_idx_in;
      pick_left_ff  <= pick_left_in;
      pick_len_ff   <= pick_len_in;
      pick_base_ff  <= pick_base_in;
      split_go_ff   <= split_go_in;
      res_status_ff <= res_status_in;
      res_base_ff   <= res_base_in;
      res_index_ff  <= res_index_in;
      rsp_tuser_ff  <= rsp_tuser_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

`ifndef NO_ASSERTIONS
   // a new result only appears out of the completion state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff) == FSM_DONE)
      else $error("response raised outside completion state");

   // a grant never lands on an entry that is already busy
   a_grant_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_GRANT) |-> !busy_ff[pick_idx_ff])
      else $error("grant of a busy entry");

   // the table grows by one entry at a time
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff))
         |-> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("entry count jumped");
`endif

endmodule

FILE: rtl/pfa_ram.sv
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
